>>> hdl/hkrb_pkg.sv
package hkrb_pkg;

   localparam int unsigned CODE_W = 8;
   localparam int unsigned REPORT_SLOTS = 6;

   localparam logic [CODE_W-1:0] MOD_MATCH_MASK  = 8'hF8;
   localparam logic [CODE_W-1:0] MOD_MATCH_VALUE = 8'hE0;
   localparam logic [CODE_W-1:0] MOD_BIT_MASK    = 8'h07;
   localparam logic [CODE_W-1:0] EMPTY_CODE      = 8'h00;

   localparam logic EVT_PRESS   = 1'b0;
   localparam logic EVT_RELEASE = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [CODE_W-1:0] key_code;
   } req_item_type;

   typedef struct packed {
      logic [CODE_W-1:0] modifier_bits;
      logic [CODE_W-1:0] slot_zero;
      logic [CODE_W-1:0] slot_one;
      logic [CODE_W-1:0] slot_two;
      logic [CODE_W-1:0] slot_three;
      logic [CODE_W-1:0] slot_four;
      logic [CODE_W-1:0] slot_five;
   } rsp_item_type;

   typedef struct packed {
      logic en;
      logic clear;
   } slot_wr_type;

   typedef struct packed {
      logic hit;
      logic empty;
   } slot_stat_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FILL,
      S_RESP
   } state_type;

   function automatic logic is_modifier(input logic [CODE_W-1:0] code);
      return (code & MOD_MATCH_MASK) == MOD_MATCH_VALUE;
   endfunction

endpackage

>>> hdl/hkrb_slot_file.sv
module hkrb_slot_file #(
   parameter int unsigned KEY_SLOT_COUNT = 6,
   parameter int unsigned IDX_W = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [IDX_W-1:0]                    rd_idx,
   input  logic [IDX_W-1:0]                    wr_idx,
   input  hkrb_pkg::slot_wr_type               wr,
   input  logic [hkrb_pkg::CODE_W-1:0]         code,
   output hkrb_pkg::slot_stat_type             stat,
   output logic [hkrb_pkg::CODE_W-1:0]         report [hkrb_pkg::REPORT_SLOTS]
);

   logic [hkrb_pkg::CODE_W-1:0] slot_ff [KEY_SLOT_COUNT];
   logic [hkrb_pkg::CODE_W-1:0] rd_data;
   logic [hkrb_pkg::CODE_W-1:0] wr_data;

   assign rd_data    = slot_ff[rd_idx];
   assign stat.hit   = rd_data == code;
   assign stat.empty = rd_data == hkrb_pkg::EMPTY_CODE;
   assign wr_data    = wr.clear ? hkrb_pkg::EMPTY_CODE : code;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_SLOT_COUNT; i++) begin
            slot_ff[i] <= hkrb_pkg::EMPTY_CODE;
         end
      end else if (wr.en) begin
         slot_ff[wr_idx] <= wr_data;
      end
   end

   for (genvar g = 0; g < hkrb_pkg::REPORT_SLOTS; g++) begin : g_report
      if (g < KEY_SLOT_COUNT) begin : g_held
         assign report[g] = slot_ff[g];
      end else begin : g_absent
         assign report[g] = hkrb_pkg::EMPTY_CODE;
      end
   end

endmodule

>>> hdl/hkrb_seq.sv
module hkrb_seq #(
   parameter int unsigned KEY_SLOT_COUNT = 6,
   parameter int unsigned IDX_W = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  hkrb_pkg::req_item_type        req_item,
   input  hkrb_pkg::slot_stat_type       stat,
   output logic                          busy,
   output logic                          rsp_strobe,
   output logic [IDX_W-1:0]              rd_idx,
   output logic [IDX_W-1:0]              wr_idx,
   output hkrb_pkg::slot_wr_type         wr,
   output logic [hkrb_pkg::CODE_W-1:0]   code
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOT_COUNT - 1);

   hkrb_pkg::state_type         state_ff, state_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [IDX_W-1:0]            first_ff, first_in;
   logic                        found_ff, found_in;
   logic                        release_ff, release_in;
   logic [hkrb_pkg::CODE_W-1:0] code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hkrb_pkg::S_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
      idx_ff     <= idx_in;
      first_ff   <= first_in;
      release_ff <= release_in;
      code_ff    <= code_in;
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      first_in   = first_ff;
      found_in   = found_ff;
      release_in = release_ff;
      code_in    = code_ff;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      wr.en      = 1'b0;
      wr.clear   = 1'b0;
      wr_idx     = idx_ff;
      unique case (state_ff)
         hkrb_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               release_in = req_item.req_type == hkrb_pkg::EVT_RELEASE;
               code_in    = req_item.key_code;
               idx_in     = '0;
               found_in   = 1'b0;
               state_in   = hkrb_pkg::is_modifier(req_item.key_code) ?
                            hkrb_pkg::S_RESP : hkrb_pkg::S_SCAN;
            end
         end
         hkrb_pkg::S_SCAN: begin
            wr.en    = stat.hit;
            wr.clear = 1'b1;
            if (!found_ff && (stat.hit || stat.empty)) begin
               found_in = 1'b1;
               first_in = idx_ff;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = release_ff ? hkrb_pkg::S_RESP : hkrb_pkg::S_FILL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         hkrb_pkg::S_FILL: begin
            wr.en    = found_ff;
            wr_idx   = first_ff;
            state_in = hkrb_pkg::S_RESP;
         end
         hkrb_pkg::S_RESP: begin
            rsp_strobe = 1'b1;
            state_in   = hkrb_pkg::S_IDLE;
         end
         default: begin
            state_in = hkrb_pkg::S_IDLE;
         end
      endcase
   end

   assign rd_idx = idx_ff;
   assign code   = code_ff;

endmodule

>>> hdl/hid_keyboard_report_builder_core.sv
// Channel   Ports                        Handshake
// request   start, busy, req_item        taken when start high and busy low
// response  rsp_valid, rsp_item          one-cycle strobe, cannot be held off
//
// A modifier item reaches the response strobe in the cycle after acceptance.
// Any other key passes the slot scan, then the fill state (skipped on release), before
// the strobe; the scan goes through the single shared compare unit, one slot a cycle.
// busy rises once an item is accepted and stays high until the cycle after the strobe.
// Synchronous reset clears the modifier byte and all slots.
module hid_keyboard_report_builder_core #(
   parameter int unsigned KEY_SLOT_COUNT = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  hkrb_pkg::req_item_type req_item,
   output logic                   busy,
   output logic                   rsp_valid,
   output hkrb_pkg::rsp_item_type rsp_item
);

   localparam int unsigned IDX_W = (KEY_SLOT_COUNT > 1) ? $clog2(KEY_SLOT_COUNT) : 1;

   logic [hkrb_pkg::CODE_W-1:0] modifier_ff, modifier_in;
   logic [hkrb_pkg::CODE_W-1:0] mod_bit;
   logic                        accept;
   logic [IDX_W-1:0]            rd_idx;
   logic [IDX_W-1:0]            wr_idx;
   hkrb_pkg::slot_wr_type       wr;
   hkrb_pkg::slot_stat_type     stat;
   logic [hkrb_pkg::CODE_W-1:0] code;
   logic [hkrb_pkg::CODE_W-1:0] report [hkrb_pkg::REPORT_SLOTS];

   assign accept  = start && !busy;
   assign mod_bit = hkrb_pkg::CODE_W'(1) << (req_item.key_code & hkrb_pkg::MOD_BIT_MASK);

   always_comb begin
      modifier_in = modifier_ff;
      if (accept && hkrb_pkg::is_modifier(req_item.key_code)) begin
         modifier_in = (req_item.req_type == hkrb_pkg::EVT_RELEASE) ?
                       (modifier_ff & ~mod_bit) : (modifier_ff | mod_bit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modifier_ff <= '0;
      end else begin
         modifier_ff <= modifier_in;
      end
   end

   hkrb_seq #(
      .KEY_SLOT_COUNT(KEY_SLOT_COUNT),
      .IDX_W         (IDX_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .stat      (stat),
      .busy      (busy),
      .rsp_strobe(rsp_valid),
      .rd_idx    (rd_idx),
      .wr_idx    (wr_idx),
      .wr        (wr),
      .code      (code)
   );

   hkrb_slot_file #(
      .KEY_SLOT_COUNT(KEY_SLOT_COUNT),
      .IDX_W         (IDX_W)
   ) u_slot_file (
      .clock (clock),
      .reset (reset),
      .rd_idx(rd_idx),
      .wr_idx(wr_idx),
      .wr    (wr),
      .code  (code),
      .stat  (stat),
      .report(report)
   );

   assign rsp_item.modifier_bits = modifier_ff;
   assign rsp_item.slot_zero     = report[0];
   assign rsp_item.slot_one      = report[1];
   assign rsp_item.slot_two      = report[2];
   assign rsp_item.slot_three    = report[3];
   assign rsp_item.slot_four     = report[4];
   assign rsp_item.slot_five     = report[5];

`ifndef NO_ASSERTIONS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accepting an item");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while idle");

   a_release_after_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy still high after the response");

   a_modifier_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> $stable(modifier_ff))
      else $error("modifier byte changed with no item");
`endif

endmodule
